@@ design/u2u8o_pkg.sv @@
// shared types, constants and encoding functions of the utf-16 to utf-8 transcoder
`default_nettype none

package u2u8o_pkg;

  // widths fixed by the item fields
  localparam int UNIT_W              = 16;
  localparam int BYTE_W              = 8;
  localparam int OUT_OFF_W           = 32;
  localparam int CP_W                = 21;
  localparam int DEFAULT_OFFSET_BITS = 32;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // fixed operation slots of one job, carried out in this order
  localparam int            NUM_SLOTS  = 4;
  localparam logic [1:0]    SLOT_HELD  = 2'd0;  // held high surrogate: pair or replacement
  localparam logic [1:0]    SLOT_UNIT  = 2'd1;  // the unit itself
  localparam logic [1:0]    SLOT_FLUSH = 2'd2;  // end-of-text flush of a held surrogate
  localparam logic [1:0]    SLOT_CLOSE = 2'd3;  // closing entry, no byte

  // code point constants
  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [CP_W-1:0] CP_LIMIT_1     = 21'h000080;
  localparam logic [CP_W-1:0] CP_LIMIT_2     = 21'h000800;
  localparam logic [CP_W-1:0] CP_LIMIT_3     = 21'h010000;

  // utf-8 lead and continuation marks
  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT   = 8'h80;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              has_unit;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    utf8_byte;
    logic                 has_byte;
    logic [OUT_OFF_W-1:0] source_offset;
    logic                 last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CP_W-1:0]      cp;
    logic [OUT_OFF_W-1:0] offset;
  } op_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] valid;
    op_t  [NUM_SLOTS-1:0] ops;
  } job_t;

  // number of utf-8 bytes for a code point
  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] len;
    if (cp < CP_LIMIT_1) begin
      len = 3'd1;
    end else if (cp < CP_LIMIT_2) begin
      len = 3'd2;
    end else if (cp < CP_LIMIT_3) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // byte k of the utf-8 encoding of a code point
  function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
                                                  input logic [1:0] k);
    logic [2:0]        len;
    logic [BYTE_W-1:0] b;
    len = utf8_len(cp);
    b   = '0;
    case (len)
      3'd1: b = cp[7:0];
      3'd2: begin
        case (k)
          2'd0:    b = LEAD_2 | {3'b000, cp[10:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (k)
          2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
          2'd1:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
          2'd1:    b = CONT | {2'b00, cp[17:12]};
          2'd2:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/u2u8o_front.sv @@
// front end: surrogate pairing, unit counting and job building
`default_nettype none

module u2u8o_front
  import u2u8o_pkg::*;
#(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t unit_item,
  input  wire logic     accept,
  output job_t          job,
  output logic          job_valid
);

  logic [9:0]             held_high_bits, held_high_bits_next;
  logic                   held_valid, held_valid_next;
  logic [OUT_OFF_W-1:0]   held_offset, held_offset_next;
  logic [OFFSET_BITS-1:0] unit_index, unit_index_next;

  logic is_high, is_low;

  // surrogate classes
  always_comb begin
    is_high = unit_item.code_unit inside {[16'hD800:16'hDBFF]};
    is_low  = unit_item.code_unit inside {[16'hDC00:16'hDFFF]};
  end

  // build the job for this item and the next state
  always_comb begin
    job                 = '0;
    held_high_bits_next = held_high_bits;
    held_valid_next     = held_valid;
    held_offset_next    = held_offset;
    unit_index_next     = unit_index;

    if (unit_item.has_unit) begin
      if (unit_index != '1) begin
        unit_index_next = unit_index + 1'b1;
      end
      if (held_valid && is_low) begin
        job.valid[SLOT_HELD]      = 1'b1;
        job.ops[SLOT_HELD].cp     = CP_SUPP_BASE +
                                    CP_W'({held_high_bits, unit_item.code_unit[9:0]});
        job.ops[SLOT_HELD].offset = held_offset;
        held_valid_next           = 1'b0;
      end else begin
        if (held_valid) begin
          job.valid[SLOT_HELD]      = 1'b1;
          job.ops[SLOT_HELD].cp     = CP_REPLACEMENT;
          job.ops[SLOT_HELD].offset = held_offset;
          held_valid_next           = 1'b0;
        end
        if (is_high) begin
          held_high_bits_next = unit_item.code_unit[9:0];
          held_offset_next    = OUT_OFF_W'(unit_index);
          held_valid_next     = 1'b1;
        end else begin
          job.valid[SLOT_UNIT]      = 1'b1;
          job.ops[SLOT_UNIT].cp     = is_low ? CP_REPLACEMENT
                                             : CP_W'(unit_item.code_unit);
          job.ops[SLOT_UNIT].offset = OUT_OFF_W'(unit_index);
        end
      end
    end

    // end of text: flush a held surrogate, then the closing entry
    if (unit_item.end_of_text) begin
      if (held_valid_next) begin
        job.valid[SLOT_FLUSH]      = 1'b1;
        job.ops[SLOT_FLUSH].cp     = CP_REPLACEMENT;
        job.ops[SLOT_FLUSH].offset = held_offset_next;
        held_valid_next            = 1'b0;
      end
      job.valid[SLOT_CLOSE]      = 1'b1;
      job.ops[SLOT_CLOSE].offset = OUT_OFF_W'(unit_index_next);
      unit_index_next            = '0;
    end
  end

  assign job_valid = accept && (|job.valid);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      unit_index <= '0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      unit_index <= unit_index_next;
    end
  end

  // held surrogate payload
  always_ff @(posedge clk) begin
    if (accept) begin
      held_high_bits <= held_high_bits_next;
      held_offset    <= held_offset_next;
    end
  end

endmodule

`default_nettype wire

@@ design/u2u8o_queue.sv @@
// short job queue between front and back
`default_nettype none

module u2u8o_queue
  import u2u8o_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t wr_job,
  input  wire logic wr,
  output logic      full,
  output job_t      rd_job,
  output logic      rd_valid,
  input  wire logic rd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/u2u8o_back.sv @@
// back end: expands jobs into utf-8 bytes, one result item per cycle while a job waits and the receiver takes them
`default_nettype none

module u2u8o_back
  import u2u8o_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic head_valid,
  output logic      head_pop,
  output out_item_t byte_item,
  output logic      empty,
  input  wire logic pop
);

  logic [NUM_SLOTS-1:0] done;
  logic [1:0]           k;
  logic                 out_valid;

  logic [NUM_SLOTS-1:0] rem, rem_after;
  logic [1:0]           cur;
  op_t                  cur_op;
  logic                 is_close;
  logic [2:0]           len;
  logic [BYTE_W-1:0]    cur_byte;
  logic                 last_byte;
  logic                 advance;

  // pick the lowest slot still to do
  always_comb begin
    rem = head.valid & ~done;
    if (rem[0]) begin
      cur = SLOT_HELD;
    end else if (rem[1]) begin
      cur = SLOT_UNIT;
    end else if (rem[2]) begin
      cur = SLOT_FLUSH;
    end else begin
      cur = SLOT_CLOSE;
    end
    rem_after = rem & ~(NUM_SLOTS'(1) << cur);
  end

  // encode the current byte
  always_comb begin
    cur_op    = head.ops[cur];
    is_close  = (cur == SLOT_CLOSE);
    len       = is_close ? 3'd1 : utf8_len(cur_op.cp);
    cur_byte  = is_close ? '0 : utf8_byte(cur_op.cp, k);
    last_byte = (({1'b0, k} + 3'd1) == len);
  end

  assign advance  = head_valid && (!out_valid || pop);
  assign head_pop = advance && last_byte && (rem_after == '0);
  assign empty    = !out_valid;

  // sequencing through slots and bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (last_byte) begin
          k <= '0;
          if (rem_after == '0) begin
            done <= '0;
          end else begin
            done <= done | (NUM_SLOTS'(1) << cur);
          end
        end else begin
          k <= k + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_item.utf8_byte     <= cur_byte;
      byte_item.has_byte      <= !is_close;
      byte_item.source_offset <= cur_op.offset;
      byte_item.last_of_run   <= last_byte && (rem_after == '0);
    end
  end

  // a queued job always has work left
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (rem != '0))
    else $error("job at head with no slot left");

  // byte index stays inside the current code point
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, k} < len))
    else $error("byte index past end of code point");

  // no partial progress without a job
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (done == '0 && k == '0))
    else $error("progress state left over without a job");

  // closing entry carries no byte and ends its run
  a_close_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_item.has_byte) |->
      (byte_item.utf8_byte == '0 && byte_item.last_of_run))
    else $error("malformed closing entry");

endmodule

`default_nettype wire

@@ design/utf16_to_utf8_with_offsets_unit.sv @@
// top level of the utf-16 to utf-8 transcoder with source offsets
//
// Input channel: one UTF-16 code unit per item, with has_unit and end_of_text
// flags; taken at a clock edge with push high and full low. Result channel:
// one UTF-8 byte per item, tagged with the index of the unit where its code
// point starts; shown while empty is low, taken with pop high.
// The front end pairs surrogates and counts units, the back end expands each
// job into bytes, and a two-entry job queue sits between them.
// Each item's job is written into the queue, and its results are registered
// in the back end's result register. Throughput: one result per cycle while
// jobs wait and the receiver takes them, set by the single byte encoder in the
// back end; an item gives up to seven results, three for a typical BMP unit.
// A stalled receiver holds the result register; the queue still takes up to
// two further items before full rises.
// Reset (synchronous, active high) drops the held surrogate, the unit count,
// queued jobs and the waiting result.
`default_nettype none

module utf16_to_utf8_with_offsets_unit
  import u2u8o_pkg::*;
#(
  parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t unit_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     byte_item
);

  job_t front_job, head_job;
  logic front_job_valid, head_valid, head_pop;
  logic accept;

  assign accept = push && !full;

  // classification and surrogate state
  u2u8o_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .unit_item (unit_item),
    .accept    (accept),
    .job       (front_job),
    .job_valid (front_job_valid)
  );

  // job queue
  u2u8o_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr       (front_job_valid),
    .full     (full),
    .rd_job   (head_job),
    .rd_valid (head_valid),
    .rd       (head_pop)
  );

  // byte expansion
  u2u8o_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .byte_item  (byte_item),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire
